// File: rtl/ctk_pkg.sv
// shared types, tables and character classes for the source tokenizer
package ctk_pkg;

  typedef enum logic [3:0] {
    TK_IDENT   = 4'd0,
    TK_KEYWORD = 4'd1,
    TK_INT     = 4'd2,
    TK_FLOAT   = 4'd3,
    TK_STRING  = 4'd4,
    TK_CHAR    = 4'd5,
    TK_PP      = 4'd6,
    TK_OP      = 4'd7,
    TK_UNKNOWN = 4'd8,
    TK_END     = 4'd9,
    TK_ERROR   = 4'd10
  } tok_kind_e;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_BCOM = 2'd1;
  localparam logic [1:0] ERR_STR  = 2'd2;
  localparam logic [1:0] ERR_CHAR = 2'd3;

  typedef enum logic {
    JOB_PROC,
    JOB_FINAL
  } job_op_e;

  // one scan step: byte under the cursor plus two bytes of lookahead
  typedef struct packed {
    job_op_e    op;
    logic [7:0] c0;
    logic [7:0] c1;
    logic [7:0] c2;
    logic       last;
  } job_t;

  localparam int JobDepth  = 4;
  localparam int KwTable   = 61;
  localparam int KwChars   = 16;

  // right-justified, zero padded on the left
  localparam logic [8*KwChars-1:0] KW_STR [KwTable] = '{
    "auto", "bool", "break", "case", "catch", "char", "class", "const",
    {"const", "_cast"}, "continue", "default", "delete", "do", "double",
    {"dynamic", "_cast"}, "else", "enum", "explicit", "extern", "false", "float",
    "for", "friend", "goto", "if", "inline", "int", "long", "mutable",
    "namespace", "new", "operator", "private", "protected", "public",
    "register", {"reinterpret", "_cast"}, "return", "short", "signed", "sizeof",
    "static", {"static", "_cast"}, "struct", "switch", "template", "this", "throw",
    "true", "try", "typedef", "typeid", "typename", "union", "unsigned",
    "using", "virtual", "void", "volatile", "wchar_t", "while"
  };

  localparam logic [8*12-1:0] OP3_STR = "...<<=>>=->*";
  localparam logic [8*42-1:0] OP2_STR =
    "==!=<=>=&&||<<>>+=-=*=/=%=&=|=^=++--->::.*";
  localparam logic [8*24-1:0] OP1_STR = "+-*/%=<>!&|^~?.(){}[];:,";

  typedef struct packed {
    logic       hit;
    logic [5:0] sub;
    logic [1:0] n;
  } op_hit_t;

  function automatic int kw_len(int k);
    int n;
    n = 0;
    for (int j = 0; j < KwChars; j++) begin
      if (KW_STR[k][8*j +: 8] != 8'h00) n++;
    end
    return n;
  endfunction

  function automatic logic [7:0] kw_char(int k, logic [4:0] i);
    logic [8*KwChars-1:0] s;
    s = KW_STR[k] << (8 * (KwChars - kw_len(k)));
    if (i >= 5'(KwChars)) return 8'h00;
    return s[8*(KwChars-1-int'(i[3:0])) +: 8];
  endfunction

  function automatic op_hit_t op_match(logic [7:0] c0, logic [7:0] c1, logic [7:0] c2);
    op_hit_t r;
    r.hit = 1'b0;
    r.sub = 6'd0;
    r.n   = 2'd1;
    for (int i = 0; i < 4; i++) begin
      if (!r.hit && c0 == OP3_STR[8*(11-3*i) +: 8] && c1 == OP3_STR[8*(10-3*i) +: 8]
          && c2 == OP3_STR[8*(9-3*i) +: 8]) begin
        r.hit = 1'b1;
        r.sub = 6'(i);
        r.n   = 2'd3;
      end
    end
    for (int i = 0; i < 21; i++) begin
      if (!r.hit && c0 == OP2_STR[8*(41-2*i) +: 8] && c1 == OP2_STR[8*(40-2*i) +: 8]) begin
        r.hit = 1'b1;
        r.sub = 6'(4 + i);
        r.n   = 2'd2;
      end
    end
    for (int i = 0; i < 24; i++) begin
      if (!r.hit && c0 == OP1_STR[8*(23-i) +: 8]) begin
        r.hit = 1'b1;
        r.sub = 6'(25 + i);
      end
    end
    return r;
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0a || c == 8'h0d || c == 8'h0c || c == 8'h0b;
  endfunction

  function automatic logic is_num(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_hex(logic [7:0] c);
    return is_num(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic is_word0(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_word(logic [7:0] c);
    return is_word0(c) || is_num(c);
  endfunction

endpackage

// File: rtl/ctk_front.sv
// front end: lookahead window, turns bytes and end marks into scan jobs
module ctk_front import ctk_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_code_i,
  input  logic       end_of_input_i,
  output logic       job_valid_o,
  output job_t       job_o,
  input  logic       job_ready_i
);

  logic [7:0] la0_q, la0_d, la1_q, la1_d;
  logic [1:0] cnt_q, cnt_d;
  logic       flush_q, flush_d;

  assign in_ready_o = !flush_q && job_ready_i;

  always_comb begin
    la0_d       = la0_q;
    la1_d       = la1_q;
    cnt_d       = cnt_q;
    flush_d     = flush_q;
    job_valid_o = 1'b0;
    job_o       = '{op: JOB_PROC, c0: 8'h00, c1: 8'h00, c2: 8'h00, last: 1'b0};
    if (in_valid_i && in_ready_o) begin
      if (end_of_input_i) begin
        flush_d = 1'b1;
      end else begin
        case (cnt_q)
          2'd0: begin
            la0_d = char_code_i;
            cnt_d = 2'd1;
          end
          2'd1: begin
            la1_d = char_code_i;
            cnt_d = 2'd2;
          end
          default: begin
            job_valid_o = 1'b1;
            job_o = '{op: JOB_PROC, c0: la0_q, c1: la1_q, c2: char_code_i, last: 1'b1};
            la0_d = la1_q;
            la1_d = char_code_i;
          end
        endcase
      end
    end else if (flush_q) begin
      // drain the window with missing lookahead reading as zero, then finish
      job_valid_o = 1'b1;
      if (cnt_q != 2'd0) begin
        job_o = '{op: JOB_PROC, c0: la0_q, c1: (cnt_q == 2'd2) ? la1_q : 8'h00,
                  c2: 8'h00, last: 1'b0};
        if (job_ready_i) begin
          la0_d = la1_q;
          cnt_d = cnt_q - 2'd1;
        end
      end else begin
        job_o = '{op: JOB_FINAL, c0: 8'h00, c1: 8'h00, c2: 8'h00, last: 1'b1};
        if (job_ready_i) flush_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= 2'd0;
      flush_q <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      flush_q <= flush_d;
    end
  end

  always_ff @(posedge clk_i) begin
    la0_q <= la0_d;
    la1_q <= la1_d;
  end

endmodule

// File: rtl/ctk_job_queue.sv
// small job queue between front end and scanner
module ctk_job_queue import ctk_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  job_t push_job_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output job_t pop_job_o
);

  localparam int PtrW = $clog2(JobDepth);

  job_t                mem_q [JobDepth];
  logic [PtrW-1:0]     wp_q, rp_q;
  logic [PtrW:0]       cnt_q;
  logic                push, pop;

  assign push_ready_o = cnt_q != (PtrW+1)'(JobDepth);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_job_o    = mem_q[rp_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= wp_q + 1'b1;
      if (pop) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= push_job_i;
  end

endmodule

// File: rtl/ctk_back.sv
// scanner: runs the lexer state machine on each job and buffers tokens
module ctk_back import ctk_pkg::*; #(
  parameter int LINE_WIDTH         = 20,
  parameter int COLUMN_WIDTH       = 16,
  parameter int OFFSET_WIDTH       = 24,
  parameter int KEYWORD_COUNT      = 61,
  parameter int MAX_KEYWORD_LENGTH = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    job_valid_i,
  output logic                    job_ready_o,
  input  job_t                    job_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [3:0]              token_kind_o,
  output logic [5:0]              sub_index_o,
  output logic [LINE_WIDTH-1:0]   start_line_o,
  output logic [COLUMN_WIDTH-1:0] start_column_o,
  output logic [OFFSET_WIDTH-1:0] start_offset_o,
  output logic [15:0]             token_length_o,
  output logic                    joins_previous_o,
  output logic [1:0]              error_code_o,
  output logic                    last_in_run_o
);

  localparam int LW  = LINE_WIDTH;
  localparam int CW  = COLUMN_WIDTH;
  localparam int OW  = OFFSET_WIDTH;
  localparam int KwN = (KEYWORD_COUNT < KwTable) ? KEYWORD_COUNT : KwTable;

  typedef enum logic [4:0] {
    M_IDLE, M_LCOM, M_BOPEN, M_BCOM, M_DROP, M_IDENT, M_HEXX, M_HEX, M_DEC, M_FRAC,
    M_ESIGN, M_EDIG, M_USUF, M_I1, M_I2, M_STR, M_STRESC, M_CHOPEN, M_CHESC,
    M_CHCLOSE, M_PP, M_PPCONT
  } mode_e;

  typedef struct packed {
    tok_kind_e     kind;
    logic [5:0]    sub;
    logic [LW-1:0] line;
    logic [CW-1:0] col;
    logic [OW-1:0] off;
    logic [15:0]   len;
    logic          joins;
    logic [1:0]    err;
    logic          last;
  } tok_t;

  function automatic tok_t mk_tok(tok_kind_e k, logic [5:0] s, logic [15:0] len,
                                  logic j, logic [1:0] e, logic [LW-1:0] l,
                                  logic [CW-1:0] c, logic [OW-1:0] o);
    tok_t t;
    t.kind  = k;
    t.sub   = s;
    t.line  = l;
    t.col   = c;
    t.off   = o;
    t.len   = len;
    t.joins = j;
    t.err   = e;
    t.last  = 1'b0;
    return t;
  endfunction

  mode_e          mode_q, mode_d;
  logic [LW-1:0]  ln_q, ln_d, sl_q, sl_d;
  logic [CW-1:0]  cl_q, cl_d, sc_q, sc_d;
  logic [OW-1:0]  of_q, of_d, so_q, so_d;
  logic [KwN-1:0] ka_q, ka_d;
  logic [4:0]     il_q, il_d;
  logic           fs_q, fs_d, ls_q, ls_d, jn_q, jn_d, er_q, er_d;
  logic [15:0]    tr_q, tr_d, tl_q, tl_d;
  logic [1:0]     dl_q, dl_d;

  tok_t           em [2];
  logic [1:0]     ne;
  logic           job_pop, out_pop;

  tok_t           ob_q [4];
  logic [1:0]     owr_q, ord_q;
  logic [2:0]     ocnt_q;

  assign job_ready_o = ocnt_q <= 3'd2;
  assign job_pop     = job_valid_i && job_ready_o;
  assign out_valid_o = ocnt_q != 3'd0;
  assign out_pop     = out_valid_o && out_ready_i;

  always_comb begin : scan
    mode_e          m;
    logic [LW-1:0]  ln, sl;
    logic [CW-1:0]  cl, sc;
    logic [OW-1:0]  of, so;
    logic [KwN-1:0] ka;
    logic [4:0]     il;
    logic           fs, ls, jn, er;
    logic [15:0]    tr, tl;
    logic [1:0]     dl;
    logic           ec, ed, ae, is, fin_id, fin_num, idl, take, ea, kwhit;
    logic [5:0]     kwsub;
    op_hit_t        oh;
    logic [7:0]     c0, c1, c2;

    m = mode_q; ln = ln_q; cl = cl_q; of = of_q; sl = sl_q; sc = sc_q; so = so_q;
    ka = ka_q; il = il_q; fs = fs_q; ls = ls_q; jn = jn_q; er = er_q;
    tr = tr_q; tl = tl_q; dl = dl_q;
    ec = 1'b0; ed = 1'b0; ae = 1'b0; is = 1'b0; fin_id = 1'b0; fin_num = 1'b0;
    idl = 1'b0; take = 1'b0; ea = 1'b0; kwhit = 1'b0; kwsub = 6'd0;
    oh = '0;
    c0 = job_i.c0; c1 = job_i.c1; c2 = job_i.c2;
    em[0] = '0; em[1] = '0; ne = 2'd0;

    if (job_i.op == JOB_PROC) begin
      if (!er) begin
        unique case (m)
          M_LCOM: begin
            ea = 1'b1;
            if (c0 == 8'h0a) m = M_IDLE;
          end
          M_BOPEN: begin
            ea = 1'b1;
            m  = M_BCOM;
          end
          M_BCOM: begin
            if (c0 == "*" && c1 == "/") begin
              dl = 2'd1;
              m  = M_DROP;
            end
            ea = 1'b1;
          end
          M_DROP: begin
            ea = 1'b1;
            if (dl != 2'd0) dl = dl - 2'd1;
            if (dl == 2'd0) m = M_IDLE;
          end
          M_IDENT: begin
            if (is_word(c0)) begin
              take = 1'b1;
              ea   = 1'b1;
            end else begin
              fin_id = 1'b1;
              idl    = 1'b1;
            end
          end
          M_HEXX: begin
            tl = (&tl) ? tl : tl + 16'd1;
            ea = 1'b1;
            m  = M_HEX;
          end
          M_HEX: begin
            if (is_hex(c0)) begin
              tl = (&tl) ? tl : tl + 16'd1;
              ea = 1'b1;
            end else is = 1'b1;
          end
          M_DEC: begin
            if (is_num(c0)) begin
              tl = (&tl) ? tl : tl + 16'd1;
              ea = 1'b1;
            end else if (c0 == "." && c1 != ".") begin
              fs = 1'b1;
              tl = (&tl) ? tl : tl + 16'd1;
              ea = 1'b1;
              m  = M_FRAC;
            end else ec = 1'b1;
          end
          M_FRAC: begin
            if (is_num(c0)) begin
              tl = (&tl) ? tl : tl + 16'd1;
              ea = 1'b1;
            end else ec = 1'b1;
          end
          M_ESIGN: begin
            if (c0 == "+" || c0 == "-") begin
              tl = (&tl) ? tl : tl + 16'd1;
              ea = 1'b1;
              m  = M_EDIG;
            end else ed = 1'b1;
          end
          M_EDIG:  ed = 1'b1;
          M_USUF:  is = 1'b1;
          M_I1: begin
            ea = 1'b1;
            m  = M_I2;
          end
          M_I2: begin
            if (is_num(c0)) begin
              ea      = 1'b1;
              fin_num = 1'b1;
            end else begin
              fin_num = 1'b1;
              idl     = 1'b1;
            end
          end
          M_STR: begin
            if (c0 == "\"") begin
              ea = 1'b1;
              em[ne[0]] = mk_tok(TK_STRING, 6'd0, tl, jn, ERR_NONE, sl, sc, so);
              ne = ne + 2'd1;
              ls = 1'b1;
              m  = M_IDLE;
            end else if (c0 == 8'h0a) begin
              em[ne[0]] = mk_tok(TK_ERROR, 6'd0, 16'd0, 1'b0, ERR_STR, sl, sc, so);
              ne = ne + 2'd1;
              ls = 1'b0;
              er = 1'b1;
            end else begin
              tl = (&tl) ? tl : tl + 16'd1;
              ea = 1'b1;
              if (c0 == "\\") m = M_STRESC;
            end
          end
          M_STRESC: begin
            tl = (&tl) ? tl : tl + 16'd1;
            ea = 1'b1;
            m  = M_STR;
          end
          M_CHOPEN: begin
            if (c0 == "'") begin
              ea = 1'b1;
              em[ne[0]] = mk_tok(TK_CHAR, 6'd0, tl, 1'b0, ERR_NONE, sl, sc, so);
              ne = ne + 2'd1;
              ls = 1'b0;
              m  = M_IDLE;
            end else begin
              tl = (&tl) ? tl : tl + 16'd1;
              ea = 1'b1;
              m  = (c0 == "\\") ? M_CHESC : M_CHCLOSE;
            end
          end
          M_CHESC: begin
            tl = (&tl) ? tl : tl + 16'd1;
            ea = 1'b1;
            m  = M_CHCLOSE;
          end
          M_CHCLOSE: begin
            if (c0 == "'") begin
              ea = 1'b1;
              em[ne[0]] = mk_tok(TK_CHAR, 6'd0, tl, 1'b0, ERR_NONE, sl, sc, so);
              ne = ne + 2'd1;
              ls = 1'b0;
              m  = M_IDLE;
            end else begin
              em[ne[0]] = mk_tok(TK_ERROR, 6'd0, 16'd0, 1'b0, ERR_CHAR, sl, sc, so);
              ne = ne + 2'd1;
              ls = 1'b0;
              er = 1'b1;
            end
          end
          M_PP: begin
            if (c0 == 8'h0a) begin
              em[ne[0]] = mk_tok(TK_PP, 6'd0, tr, 1'b0, ERR_NONE, sl, sc, so);
              ne  = ne + 2'd1;
              ls  = 1'b0;
              idl = 1'b1;
            end else begin
              tl = (&tl) ? tl : tl + 16'd1;
              if (!is_space(c0)) tr = tl;
              if (c0 == "\\" && c1 == 8'h0a) m = M_PPCONT;
              ea = 1'b1;
            end
          end
          M_PPCONT: begin
            tl = (&tl) ? tl : tl + 16'd1;
            ea = 1'b1;
            m  = M_PP;
          end
          default: idl = 1'b1;
        endcase

        // number tail: exponent, float and integer suffixes
        if (ec) begin
          if (c0 == "e" || c0 == "E") begin
            fs = 1'b1;
            tl = (&tl) ? tl : tl + 16'd1;
            ea = 1'b1;
            m  = M_ESIGN;
          end else ae = 1'b1;
        end
        if (ed) begin
          m = M_EDIG;
          if (is_num(c0)) begin
            tl = (&tl) ? tl : tl + 16'd1;
            ea = 1'b1;
          end else ae = 1'b1;
        end
        if (ae) begin
          if (c0 == "f" || c0 == "F" || c0 == "l" || c0 == "L") begin
            if (!fs && (c0 == "f" || c0 == "F")) fs = 1'b1;
            if (fs) begin
              tl      = (&tl) ? tl : tl + 16'd1;
              ea      = 1'b1;
              fin_num = 1'b1;
            end else is = 1'b1;
          end else is = 1'b1;
        end
        if (is) begin
          if (fs) begin
            fin_num = 1'b1;
            idl     = 1'b1;
          end else begin
            m = M_USUF;
            if (c0 == "u" || c0 == "U" || c0 == "l" || c0 == "L") begin
              tl = (&tl) ? tl : tl + 16'd1;
              ea = 1'b1;
            end else if ((c0 == "i" || c0 == "I") &&
                         (c1 == "6" || c1 == "3" || c1 == "1" || c1 == "8")) begin
              ea = 1'b1;
              m  = M_I1;
            end else begin
              fin_num = 1'b1;
              idl     = 1'b1;
            end
          end
        end
      end
    end else begin
      // end of input: flush the open token
      if (!er) begin
        case (m)
          M_IDENT: fin_id = 1'b1;
          M_HEXX, M_HEX, M_DEC, M_FRAC, M_ESIGN, M_EDIG, M_USUF, M_I1, M_I2:
            fin_num = 1'b1;
          M_PP, M_PPCONT: begin
            em[ne[0]] = mk_tok(TK_PP, 6'd0, tr, 1'b0, ERR_NONE, sl, sc, so);
            ne = ne + 2'd1;
          end
          M_STR, M_STRESC: begin
            em[ne[0]] = mk_tok(TK_ERROR, 6'd0, 16'd0, 1'b0, ERR_STR, sl, sc, so);
            ne = ne + 2'd1;
          end
          M_CHOPEN, M_CHESC, M_CHCLOSE: begin
            em[ne[0]] = mk_tok(TK_ERROR, 6'd0, 16'd0, 1'b0, ERR_CHAR, sl, sc, so);
            ne = ne + 2'd1;
          end
          M_BOPEN, M_BCOM: begin
            em[ne[0]] = mk_tok(TK_ERROR, 6'd0, 16'd0, 1'b0, ERR_BCOM, sl, sc, so);
            ne = ne + 2'd1;
          end
          default: ;
        endcase
      end
    end

    if (fin_id) begin
      if (int'(il) <= MAX_KEYWORD_LENGTH) begin
        for (int k = 0; k < KwN; k++) begin
          if (ka[k] && int'(il) == kw_len(k)) begin
            kwhit = 1'b1;
            kwsub = 6'(k);
          end
        end
      end
      em[ne[0]] = mk_tok(kwhit ? TK_KEYWORD : TK_IDENT, kwsub, tl, 1'b0, ERR_NONE,
                         sl, sc, so);
      ne = ne + 2'd1;
      ls = 1'b0;
      m  = M_IDLE;
    end
    if (fin_num) begin
      em[ne[0]] = mk_tok(fs ? TK_FLOAT : TK_INT, 6'd0, tl, 1'b0, ERR_NONE, sl, sc, so);
      ne = ne + 2'd1;
      ls = 1'b0;
      m  = M_IDLE;
    end

    // between tokens: classify the byte under the cursor
    if (idl) begin
      m = M_IDLE;
      if (is_space(c0)) begin
        ea = 1'b1;
      end else if (c0 == "/" && c1 == "/") begin
        ea = 1'b1;
        m  = M_LCOM;
      end else if (c0 == "/" && c1 == "*") begin
        sl = ln; sc = cl; so = of;
        ea = 1'b1;
        m  = M_BOPEN;
      end else if (c0 == "*" && c1 == "/") begin
        ea = 1'b1;
        dl = 2'd1;
        m  = M_DROP;
      end else begin
        sl = ln; sc = cl; so = of;
        tl = 16'd0;
        if (c0 == "#") begin
          tl = 16'd1;
          tr = 16'd1;
          ea = 1'b1;
          m  = M_PP;
        end else if (is_num(c0)) begin
          fs = 1'b0;
          tl = 16'd1;
          ea = 1'b1;
          m  = (c0 == "0" && (c1 == "x" || c1 == "X")) ? M_HEXX : M_DEC;
        end else if (c0 == "\"" || c0 == "'") begin
          so = (&so) ? so : so + 1'b1;
          jn = ls;
          ea = 1'b1;
          m  = (c0 == "\"") ? M_STR : M_CHOPEN;
        end else if (is_word0(c0)) begin
          il   = 5'd0;
          ka   = '1;
          take = 1'b1;
          ea   = 1'b1;
          m    = M_IDENT;
        end else begin
          oh = op_match(c0, c1, c2);
          em[ne[0]] = mk_tok(oh.hit ? TK_OP : TK_UNKNOWN, oh.hit ? oh.sub : 6'd0,
                             {14'd0, oh.n}, 1'b0, ERR_NONE, sl, sc, so);
          ne = ne + 2'd1;
          ls = 1'b0;
          ea = 1'b1;
          if (oh.n > 2'd1) begin
            dl = oh.n - 2'd1;
            m  = M_DROP;
          end
        end
      end
    end

    // keyword candidates drop out per byte
    if (take) begin
      for (int k = 0; k < KwN; k++) begin
        if (ka[k] && (int'(il) >= kw_len(k) || kw_char(k, il) != c0)) ka[k] = 1'b0;
      end
      if (il != 5'd31) il = il + 5'd1;
      tl = (&tl) ? tl : tl + 16'd1;
    end

    if (ea) begin
      of = (&of) ? of : of + 1'b1;
      if (c0 == 8'h0a) begin
        ln = (&ln) ? ln : ln + 1'b1;
        cl = CW'(1);
      end else begin
        cl = (&cl) ? cl : cl + 1'b1;
      end
    end

    if (job_i.op == JOB_FINAL) begin
      em[ne[0]] = mk_tok(TK_END, 6'd0, 16'd0, 1'b0, ERR_NONE, ln, cl, of);
      ne = ne + 2'd1;
      m = M_IDLE; ln = LW'(1); cl = CW'(1); of = '0; sl = LW'(1); sc = CW'(1); so = '0;
      ka = '0; il = 5'd0; fs = 1'b0; ls = 1'b0; jn = 1'b0; er = 1'b0;
      tr = 16'd0; tl = 16'd0; dl = 2'd0;
    end

    if (job_i.last && ne != 2'd0) em[ne[0] - 1'b1].last = 1'b1;

    mode_d = m; ln_d = ln; cl_d = cl; of_d = of; sl_d = sl; sc_d = sc; so_d = so;
    ka_d = ka; il_d = il; fs_d = fs; ls_d = ls; jn_d = jn; er_d = er;
    tr_d = tr; tl_d = tl; dl_d = dl;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      ln_q   <= LW'(1);
      cl_q   <= CW'(1);
      of_q   <= '0;
      sl_q   <= LW'(1);
      sc_q   <= CW'(1);
      so_q   <= '0;
      ka_q   <= '0;
      il_q   <= 5'd0;
      fs_q   <= 1'b0;
      ls_q   <= 1'b0;
      jn_q   <= 1'b0;
      er_q   <= 1'b0;
      tr_q   <= 16'd0;
      tl_q   <= 16'd0;
      dl_q   <= 2'd0;
      owr_q  <= 2'd0;
      ord_q  <= 2'd0;
      ocnt_q <= 3'd0;
    end else begin
      if (job_pop) begin
        mode_q <= mode_d;
        ln_q   <= ln_d;
        cl_q   <= cl_d;
        of_q   <= of_d;
        sl_q   <= sl_d;
        sc_q   <= sc_d;
        so_q   <= so_d;
        ka_q   <= ka_d;
        il_q   <= il_d;
        fs_q   <= fs_d;
        ls_q   <= ls_d;
        jn_q   <= jn_d;
        er_q   <= er_d;
        tr_q   <= tr_d;
        tl_q   <= tl_d;
        dl_q   <= dl_d;
        owr_q  <= owr_q + ne;
      end
      if (out_pop) ord_q <= ord_q + 2'd1;
      ocnt_q <= ocnt_q + (job_pop ? {1'b0, ne} : 3'd0) - {2'd0, out_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop && ne != 2'd0) ob_q[owr_q] <= em[0];
    if (job_pop && ne == 2'd2) ob_q[owr_q + 2'd1] <= em[1];
  end

  assign token_kind_o     = ob_q[ord_q].kind;
  assign sub_index_o      = ob_q[ord_q].sub;
  assign start_line_o     = ob_q[ord_q].line;
  assign start_column_o   = ob_q[ord_q].col;
  assign start_offset_o   = ob_q[ord_q].off;
  assign token_length_o   = ob_q[ord_q].len;
  assign joins_previous_o = ob_q[ord_q].joins;
  assign error_code_o     = ob_q[ord_q].err;
  assign last_in_run_o    = ob_q[ord_q].last;

endmodule

// File: rtl/c_source_tokenizer.sv
// top level of the streaming C/C++ source tokenizer
//
//   channel  dir  handshake                  payload
//   in       in   in_valid_i / in_ready_o    char_code_i, end_of_input_i
//   out      out  out_valid_o / out_ready_i  token_kind_o .. last_in_run_o
//
// one byte per cycle while the job queue has room and no end item is draining;
// a byte reaches the scanner once two more have arrived, and an end item holds the input while the window drains
// the scanner takes one job per cycle while its four-token buffer has two
// free slots, so output stalls back up through the job queue to in_ready_o
// reset clears the control state; lookahead bytes, queued jobs and token buffer contents are not reset
module c_source_tokenizer import ctk_pkg::*; #(
  parameter int LINE_WIDTH         = 20,
  parameter int COLUMN_WIDTH       = 16,
  parameter int OFFSET_WIDTH       = 24,
  parameter int KEYWORD_COUNT      = 61,
  parameter int MAX_KEYWORD_LENGTH = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [7:0]              char_code_i,
  input  logic                    end_of_input_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [3:0]              token_kind_o,
  output logic [5:0]              sub_index_o,
  output logic [LINE_WIDTH-1:0]   start_line_o,
  output logic [COLUMN_WIDTH-1:0] start_column_o,
  output logic [OFFSET_WIDTH-1:0] start_offset_o,
  output logic [15:0]             token_length_o,
  output logic                    joins_previous_o,
  output logic [1:0]              error_code_o,
  output logic                    last_in_run_o
);

  logic fq_valid, fq_ready, qb_valid, qb_ready;
  job_t fq_job, qb_job;

  ctk_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .char_code_i,
    .end_of_input_i,
    .job_valid_o (fq_valid),
    .job_o       (fq_job),
    .job_ready_i (fq_ready)
  );

  ctk_job_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_job_i   (fq_job),
    .pop_valid_o  (qb_valid),
    .pop_ready_i  (qb_ready),
    .pop_job_o    (qb_job)
  );

  ctk_back #(
    .LINE_WIDTH         (LINE_WIDTH),
    .COLUMN_WIDTH       (COLUMN_WIDTH),
    .OFFSET_WIDTH       (OFFSET_WIDTH),
    .KEYWORD_COUNT      (KEYWORD_COUNT),
    .MAX_KEYWORD_LENGTH (MAX_KEYWORD_LENGTH)
  ) u_back (
    .clk_i,
    .rst_ni,
    .job_valid_i (qb_valid),
    .job_ready_o (qb_ready),
    .job_i       (qb_job),
    .out_valid_o,
    .out_ready_i,
    .token_kind_o,
    .sub_index_o,
    .start_line_o,
    .start_column_o,
    .start_offset_o,
    .token_length_o,
    .joins_previous_o,
    .error_code_o,
    .last_in_run_o
  );

  // an end item blocks input while the window drains
  a_end_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && end_of_input_i |=> !in_ready_o)
    else $error("input taken right after end item");

  // the closing job of an end item always carries the run mark
  a_final_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qb_valid && qb_ready && qb_job.op == JOB_FINAL |-> qb_job.last)
    else $error("final job without run mark");

  // a token leaves the buffer only when taken
  a_out_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(out_ready_i))
    else $error("token dropped from buffer");

endmodule

// File: tb/c_source_tokenizer_tb.sv
// testbench for c_source_tokenizer: streamed source text checked against a token predictor
`timescale 1ns / 1ps

module c_source_tokenizer_tb;
  import ctk_pkg::*;

  typedef enum int {
    S_IDLE, S_LCOM, S_BOPEN, S_BCOM, S_DROP, S_IDENT, S_HEXX, S_HEX, S_DEC, S_FRAC,
    S_ESIGN, S_EDIG, S_USUF, S_I1, S_I2, S_STR, S_STRESC, S_CHOPEN, S_CHESC,
    S_CHCLOSE, S_PP, S_PPCONT
  } scan_e;

  typedef struct {
    tok_kind_e   kind;
    logic [5:0]  sub;
    logic [19:0] line;
    logic [15:0] col;
    logic [23:0] ofs;
    logic [15:0] len;
    logic        joins;
    logic [1:0]  err;
    logic        last;
  } token_t;

  typedef struct {
    logic [7:0] code;
    logic       eoi;
    logic       hold;
  } src_item_t;

  localparam int MaxTokens = 4;
  localparam int IdleLimit = 1000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  char_code_i = 8'h00;
  logic        end_of_input_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [3:0]  token_kind_o;
  logic [5:0]  sub_index_o;
  logic [19:0] start_line_o;
  logic [15:0] start_column_o;
  logic [23:0] start_offset_o;
  logic [15:0] token_length_o;
  logic        joins_previous_o;
  logic [1:0]  error_code_o;
  logic        last_in_run_o;

  c_source_tokenizer uut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .char_code_i, .end_of_input_i,
    .out_valid_o, .out_ready_i, .token_kind_o, .sub_index_o, .start_line_o,
    .start_column_o, .start_offset_o, .token_length_o, .joins_previous_o,
    .error_code_o, .last_in_run_o
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  string kw_name [61] = '{
    "auto", "bool", "break", "case", "catch", "char", "class", "const",
    string'({"const", "_cast"}), "continue", "default", "delete", "do", "double",
    string'({"dynamic", "_cast"}), "else", "enum", "explicit", "extern", "false", "float",
    "for", "friend", "goto", "if", "inline", "int", "long", "mutable",
    "namespace", "new", "operator", "private", "protected", "public",
    "register", string'({"reinterpret", "_cast"}), "return", "short", "signed", "sizeof",
    "static", string'({"static", "_cast"}), "struct", "switch", "template", "this", "throw",
    "true", "try", "typedef", "typeid", "typename", "union", "unsigned",
    "using", "virtual", "void", "volatile", "wchar_t", "while"
  };
  string ops3 = "...<<=>>=->*";
  string ops2 = "==!=<=>=&&||<<>>+=-=*=/=%=&=|=^=++--->::.*";
  string ops1 = "+-*/%=<>!&|^~?.(){}[];:,";

  // lexer state mirrored from the block
  scan_e           mode;
  int              win [3];
  int              win_n;
  longint unsigned ln, col, ofs, t_ln, t_col, t_ofs;
  bit [60:0]       kw_live;
  int              id_len, tlen, trim, drop_n;
  bit              saw_float, prev_string, err_latched, str_joins;

  token_t    step_toks[$];
  token_t    token_q[$];
  src_item_t src_q[$];
  int        failures = 0;

  function automatic longint unsigned sat(longint unsigned v, int w);
    return (v < ((64'd1 << w) - 1)) ? v + 1 : v;
  endfunction

  function automatic bit is_sp(int c);
    return c == 32 || c == 9 || c == 10 || c == 13 || c == 12 || c == 11;
  endfunction
  function automatic bit is_dig(int c);
    return c >= "0" && c <= "9";
  endfunction
  function automatic bit is_hx(int c);
    return is_dig(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction
  function automatic bit is_w0(int c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic void lex_reset();
    mode = S_IDLE;
    win = '{0, 0, 0};
    win_n = 0;
    ln = 1; col = 1; ofs = 0;
    t_ln = 1; t_col = 1; t_ofs = 0;
    kw_live = '0; id_len = 0; tlen = 0; trim = 0; drop_n = 0;
    saw_float = 0; prev_string = 0; err_latched = 0; str_joins = 0;
  endfunction

  function automatic void eat(int c);
    ofs = sat(ofs, 24);
    if (c == 10) begin
      ln = sat(ln, 20);
      col = 1;
    end else begin
      col = sat(col, 16);
    end
  endfunction

  function automatic void mark();
    t_ln = ln; t_col = col; t_ofs = ofs;
  endfunction

  function automatic void add_len();
    if (tlen < 65535) tlen++;
  endfunction

  function automatic void emit(tok_kind_e kind, int sub, int len, bit joins, logic [1:0] err);
    token_t t;
    if (step_toks.size() >= MaxTokens) return;
    t.kind = kind; t.sub = 6'(sub);
    t.line = 20'(t_ln); t.col = 16'(t_col); t.ofs = 24'(t_ofs);
    t.len = 16'(len); t.joins = joins; t.err = err; t.last = 1'b0;
    step_toks.insert(step_toks.size(), t);
    prev_string = (kind == TK_STRING);
  endfunction

  function automatic void raise_error(logic [1:0] code);
    emit(TK_ERROR, 0, 0, 0, code);
    err_latched = 1;
  endfunction

  function automatic void end_number();
    emit(saw_float ? TK_FLOAT : TK_INT, 0, tlen, 0, ERR_NONE);
    mode = S_IDLE;
  endfunction

  function automatic void ident_take(int c);
    for (int k = 0; k < 61; k++) begin
      if (kw_live[k] && (id_len >= kw_name[k].len() || int'(kw_name[k][id_len]) != c))
        kw_live[k] = 0;
    end
    if (id_len < 31) id_len++;
    add_len();
  endfunction

  function automatic void end_ident();
    tok_kind_e kind;
    int        sub;
    kind = TK_IDENT;
    sub = 0;
    if (id_len <= 16) begin
      for (int k = 0; k < 61; k++) begin
        if (kw_live[k] && kw_name[k].len() == id_len) begin
          kind = TK_KEYWORD;
          sub = k;
        end
      end
    end
    emit(kind, sub, tlen, 0, ERR_NONE);
    mode = S_IDLE;
  endfunction

  function automatic void scan_idle(int c0, int c1, int c2);
    int n, sub;
    n = 1;
    sub = -1;
    if (is_sp(c0)) begin
      eat(c0);
      return;
    end
    if (c0 == "/" && c1 == "/") begin eat(c0); mode = S_LCOM; return; end
    if (c0 == "/" && c1 == "*") begin mark(); eat(c0); mode = S_BOPEN; return; end
    if (c0 == "*" && c1 == "/") begin eat(c0); drop_n = 1; mode = S_DROP; return; end
    mark();
    tlen = 0;
    if (c0 == "#") begin
      tlen = 1; trim = 1; eat(c0); mode = S_PP;
      return;
    end
    if (is_dig(c0)) begin
      saw_float = 0;
      add_len();
      eat(c0);
      mode = (c0 == "0" && (c1 == "x" || c1 == "X")) ? S_HEXX : S_DEC;
      return;
    end
    if (c0 == "\"" || c0 == "'") begin
      t_ofs = sat(t_ofs, 24);
      str_joins = prev_string;
      eat(c0);
      mode = (c0 == "\"") ? S_STR : S_CHOPEN;
      return;
    end
    if (is_w0(c0)) begin
      id_len = 0;
      kw_live = '1;
      ident_take(c0);
      eat(c0);
      mode = S_IDENT;
      return;
    end
    for (int i = 0; i < 4 && sub < 0; i++)
      if (c0 == int'(ops3[3*i]) && c1 == int'(ops3[3*i+1]) && c2 == int'(ops3[3*i+2])) begin
        sub = i; n = 3;
      end
    for (int i = 0; i < 21 && sub < 0; i++)
      if (c0 == int'(ops2[2*i]) && c1 == int'(ops2[2*i+1])) begin
        sub = 4 + i; n = 2;
      end
    for (int i = 0; i < 24 && sub < 0; i++)
      if (c0 == int'(ops1[i])) sub = 25 + i;
    emit(sub < 0 ? TK_UNKNOWN : TK_OP, sub < 0 ? 0 : sub, n, 0, ERR_NONE);
    eat(c0);
    if (n > 1) begin
      drop_n = n - 1;
      mode = S_DROP;
    end
  endfunction

  function automatic void int_suffix(int c0, int c1, int c2);
    if (saw_float) begin
      end_number(); scan_idle(c0, c1, c2);
      return;
    end
    mode = S_USUF;
    if (c0 == "u" || c0 == "U" || c0 == "l" || c0 == "L") begin
      add_len(); eat(c0);
    end else if ((c0 == "i" || c0 == "I") &&
                 (c1 == "6" || c1 == "3" || c1 == "1" || c1 == "8")) begin
      eat(c0); mode = S_I1;
    end else begin
      end_number(); scan_idle(c0, c1, c2);
    end
  endfunction

  function automatic void after_exp(int c0, int c1, int c2);
    if (c0 == "f" || c0 == "F" || c0 == "l" || c0 == "L") begin
      if (!saw_float && (c0 == "f" || c0 == "F")) saw_float = 1;
      if (saw_float) begin
        add_len(); eat(c0); end_number();
        return;
      end
    end
    int_suffix(c0, c1, c2);
  endfunction

  function automatic void exp_digits(int c0, int c1, int c2);
    mode = S_EDIG;
    if (is_dig(c0)) begin
      add_len(); eat(c0);
    end else begin
      after_exp(c0, c1, c2);
    end
  endfunction

  function automatic void exp_check(int c0, int c1, int c2);
    if (c0 == "e" || c0 == "E") begin
      saw_float = 1; add_len(); eat(c0); mode = S_ESIGN;
    end else begin
      after_exp(c0, c1, c2);
    end
  endfunction

  function automatic void scan(int c0, int c1, int c2);
    case (mode)
      S_LCOM: begin eat(c0); if (c0 == 10) mode = S_IDLE; end
      S_BOPEN: begin eat(c0); mode = S_BCOM; end
      S_BCOM: begin
        if (c0 == "*" && c1 == "/") begin drop_n = 1; mode = S_DROP; end
        eat(c0);
      end
      S_DROP: begin
        eat(c0);
        if (drop_n > 0) drop_n--;
        if (drop_n == 0) mode = S_IDLE;
      end
      S_IDENT: begin
        if (is_w0(c0) || is_dig(c0)) begin
          ident_take(c0); eat(c0);
        end else begin
          end_ident(); scan_idle(c0, c1, c2);
        end
      end
      S_HEXX: begin add_len(); eat(c0); mode = S_HEX; end
      S_HEX: begin
        if (is_hx(c0)) begin add_len(); eat(c0); end
        else int_suffix(c0, c1, c2);
      end
      S_DEC: begin
        if (is_dig(c0)) begin
          add_len(); eat(c0);
        end else if (c0 == "." && c1 != ".") begin
          saw_float = 1; add_len(); eat(c0); mode = S_FRAC;
        end else begin
          exp_check(c0, c1, c2);
        end
      end
      S_FRAC: begin
        if (is_dig(c0)) begin add_len(); eat(c0); end
        else exp_check(c0, c1, c2);
      end
      S_ESIGN: begin
        if (c0 == "+" || c0 == "-") begin add_len(); eat(c0); mode = S_EDIG; end
        else exp_digits(c0, c1, c2);
      end
      S_EDIG: exp_digits(c0, c1, c2);
      S_USUF: int_suffix(c0, c1, c2);
      S_I1: begin eat(c0); mode = S_I2; end
      S_I2: begin
        if (is_dig(c0)) begin eat(c0); end_number(); end
        else begin end_number(); scan_idle(c0, c1, c2); end
      end
      S_STR: begin
        if (c0 == "\"") begin
          eat(c0); emit(TK_STRING, 0, tlen, str_joins, ERR_NONE); mode = S_IDLE;
        end else if (c0 == 10) begin
          raise_error(ERR_STR);
        end else begin
          add_len(); eat(c0);
          if (c0 == "\\") mode = S_STRESC;
        end
      end
      S_STRESC: begin add_len(); eat(c0); mode = S_STR; end
      S_CHOPEN: begin
        if (c0 == "'") begin
          eat(c0); emit(TK_CHAR, 0, tlen, 0, ERR_NONE); mode = S_IDLE;
        end else begin
          add_len(); eat(c0);
          mode = (c0 == "\\") ? S_CHESC : S_CHCLOSE;
        end
      end
      S_CHESC: begin add_len(); eat(c0); mode = S_CHCLOSE; end
      S_CHCLOSE: begin
        if (c0 == "'") begin
          eat(c0); emit(TK_CHAR, 0, tlen, 0, ERR_NONE); mode = S_IDLE;
        end else begin
          raise_error(ERR_CHAR);
        end
      end
      S_PP: begin
        if (c0 == 10) begin
          emit(TK_PP, 0, trim, 0, ERR_NONE); mode = S_IDLE; scan_idle(c0, c1, c2);
        end else begin
          add_len();
          if (!is_sp(c0)) trim = tlen;
          if (c0 == "\\" && c1 == 10) mode = S_PPCONT;
          eat(c0);
        end
      end
      S_PPCONT: begin add_len(); eat(c0); mode = S_PP; end
      default: begin mode = S_IDLE; scan_idle(c0, c1, c2); end
    endcase
  endfunction

  function automatic void flush_open();
    case (mode)
      S_IDENT: end_ident();
      S_HEXX, S_HEX, S_DEC, S_FRAC, S_ESIGN, S_EDIG, S_USUF, S_I1, S_I2: end_number();
      S_PP, S_PPCONT: emit(TK_PP, 0, trim, 0, ERR_NONE);
      S_STR, S_STRESC: raise_error(ERR_STR);
      S_CHOPEN, S_CHESC, S_CHCLOSE: raise_error(ERR_CHAR);
      S_BOPEN, S_BCOM: raise_error(ERR_BCOM);
      default: ;
    endcase
  endfunction

  // expected tokens for one accepted item
  function automatic void predict_tokens(logic [7:0] code, logic eoi);
    step_toks.delete();
    if (eoi) begin
      for (int i = 0; i < win_n && !err_latched; i++)
        scan(win[i], (i + 1 < win_n) ? win[i+1] : -1, (i + 2 < win_n) ? win[i+2] : -1);
      if (!err_latched) flush_open();
      mark();
      emit(TK_END, 0, 0, 0, ERR_NONE);
      lex_reset();
    end else if (!err_latched) begin
      win[win_n++] = int'(code);
      if (win_n == 3) begin
        scan(win[0], win[1], win[2]);
        win[0] = win[1];
        win[1] = win[2];
        win_n = 2;
      end
    end
    if (step_toks.size() > 0) step_toks[step_toks.size()-1].last = 1'b1;
    foreach (step_toks[i]) token_q.insert(token_q.size(), step_toks[i]);
  endfunction

  task automatic report(string what, longint unsigned got, longint unsigned want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    failures++;
  endtask

  task automatic check_field(string what, longint unsigned got, longint unsigned want);
    if (got != want) report(what, got, want);
  endtask

  // stimulus helpers
  function automatic void put_byte(int b, bit hold = 0);
    src_item_t it;
    it.code = 8'(b); it.eoi = 1'b0; it.hold = hold;
    src_q.insert(src_q.size(), it);
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) put_byte(int'(s[i]));
  endfunction

  function automatic void put_end();
    src_item_t it;
    it.code = 8'($urandom); it.eoi = 1'b1; it.hold = 1'b0;
    src_q.insert(src_q.size(), it);
  endfunction

  function automatic string rand_word(int n);
    string s, pool;
    pool = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    s = "";
    for (int i = 0; i < n; i++)
      s = {s, string'(pool[$urandom_range(0, i == 0 ? 52 : 62)])};
    return s;
  endfunction

  function automatic string rand_digits(int n, bit hex);
    string s, pool;
    pool = "0123456789abcdefABCDEF";
    s = "";
    for (int i = 0; i < n; i++) s = {s, string'(pool[$urandom_range(0, hex ? 21 : 9)])};
    return s;
  endfunction

  function automatic void put_fragment();
    string pick [$];
    case ($urandom_range(0, 15))
      0, 1: put_text(kw_name[$urandom_range(0, 60)]);
      2: put_text(rand_word($urandom_range(1, 20)));
      3: begin
        pick = '{"", "u", "UL", "l", "i64", "I8", "i3", "f"};
        put_text({"0x", rand_digits($urandom_range(0, 5), 1), pick[$urandom_range(0, 7)]});
      end
      4: begin
        pick = '{"", ".", ".5", "e", "e+", "E-3", ".25e7f", "f", "L", "..", "i16", "uL"};
        put_text({rand_digits($urandom_range(1, 4), 0), pick[$urandom_range(0, 11)]});
      end
      5: begin
        put_byte("\"");
        repeat ($urandom_range(0, 6)) begin
          case ($urandom_range(0, 5))
            0: put_text("\\\"");
            1: put_text("\\n");
            default: put_byte($urandom_range(32, 126) == 34 ? "x" : $urandom_range(35, 126));
          endcase
        end
        put_byte($urandom_range(0, 15) == 0 ? 10 : "\"");
      end
      6: begin
        pick = '{"'a'", "'\\n'", "'\\''", "''", "'ab'", "'\\"};
        put_text(pick[$urandom_range(0, 5)]);
      end
      7: begin
        put_text({"#", rand_word($urandom_range(1, 6)), " "});
        if ($urandom_range(0, 1)) put_text({rand_word(3), " \\\n "});
        put_text({rand_digits($urandom_range(1, 3), 0),
                  string'($urandom_range(0, 1) ? "  \t" : "")});
        put_byte(10);
      end
      8: put_text({"// ", rand_word(4), "\n"});
      9: put_text({"/*", rand_word($urandom_range(0, 5)),
                   string'($urandom_range(0, 12) == 0 ? "" : "*/")});
      10, 11: begin
        repeat ($urandom_range(1, 4)) begin
          case ($urandom_range(0, 2))
            0: put_text(ops3.substr(3 * $urandom_range(0, 3), 3 * $urandom_range(0, 3) + 2));
            1: begin
              int k;
              k = $urandom_range(0, 20);
              put_text(ops2.substr(2 * k, 2 * k + 1));
            end
            default: put_byte(int'(ops1[$urandom_range(0, 23)]));
          endcase
        end
      end
      12: put_text("*/");
      13: put_byte($urandom_range(0, 255));
      default: put_text({"\"", rand_word(2), "\" \"", rand_word(1), "\""});
    endcase
  endfunction

  initial begin
    string seps [4];
    lex_reset();
    // directed part
    put_text("int x=0x1Fu+3.5e-2f;");
    put_text("a<<=b->*c...d::e.*f");
    put_text(" /*c*/ */ //z\n");
    put_text("\"a\\\"\" \"b\" 'x' '\\n' 9i64 7L 1..");
    put_text("#if A \\\n B  \n");
    put_text(string'({"reinterpret", "_cast wchar_t abcdefghijklmnopq_xyz @"}));
    put_byte(0); put_byte(255);
    put_end();
    put_end();
    put_text("\"open\nzz"); put_end();
    put_text("'ab"); put_end();
    put_text("/*x"); put_end();
    // random part
    seps = '{" ", "\n", "", "\t"};
    while (src_q.size() < 500) begin
      put_fragment();
      put_text(seps[$urandom_range(0, 3)]);
      if ($urandom_range(0, 30) == 0) put_end();
      if (src_q.size() > 300 && src_q.size() < 320 && !src_q[src_q.size()-1].eoi)
        put_byte(" ", 1);
    end
    put_end();
  end

  // acceptance, prediction and checking
  logic took_in = 1'b0;
  logic took_out = 1'b0;
  int   idle_cycles = 0;

  always @(posedge clk_i) begin
    token_t want;
    took_in <= in_valid_i && in_ready_o;
    took_out <= out_valid_o && out_ready_i;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) predict_tokens(char_code_i, end_of_input_i);
      if (out_valid_o && out_ready_i) begin
        if (token_q.size() == 0) begin
          report("unexpected token kind", token_kind_o, 0);
        end else begin
          want = token_q.pop_front();
          check_field("kind", token_kind_o, want.kind);
          check_field("sub_index", sub_index_o, want.sub);
          check_field("line", start_line_o, want.line);
          check_field("start_column", start_column_o, want.col);
          check_field("start_offset", start_offset_o, want.ofs);
          check_field("token_length", token_length_o, want.len);
          check_field("joins_previous", joins_previous_o, want.joins);
          check_field("error_code", error_code_o, want.err);
          check_field("last_in_run", last_in_run_o, want.last);
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // driver and receiver stalls
  int in_gap = 0;
  int out_stall = 0;
  int cyc = 0;
  bit calm = 0;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      cyc++;
      if (cyc % 64 == 0) calm = ($urandom_range(0, 3) == 0);
      if (in_valid_i && !took_in) begin
        // hold the item
      end else if (in_gap > 0) begin
        in_valid_i <= 1'b0;
        in_gap--;
      end else if (src_q.size() > 0 && !(src_q[0].hold && token_q.size() > 0)) begin
        in_valid_i <= 1'b1;
        char_code_i <= src_q[0].code;
        end_of_input_i <= src_q[0].eoi;
        void'(src_q.pop_front());
        in_gap = calm ? 0 : $urandom_range(0, 5);
      end else begin
        in_valid_i <= 1'b0;
      end
      if (took_out) out_stall = calm ? 0 : $urandom_range(0, 5);
      out_ready_i <= (out_stall == 0);
      if (out_stall > 0) out_stall--;
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (20) @(posedge clk_i);
    while (src_q.size() > 0 || in_valid_i || token_q.size() > 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (failures == 0 && token_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/ctk_pkg.sv
rtl/ctk_front.sv
rtl/ctk_job_queue.sv
rtl/ctk_back.sv
rtl/c_source_tokenizer.sv
tb/c_source_tokenizer_tb.sv
